[rtl/load_cell_adc_reader_unit_defines.svh]
// Assertion helpers for the load cell reader.
// Both macros sample on clk and are held off while rst_n is low.
`ifndef LOAD_CELL_ADC_READER_UNIT_DEFINES_SVH
`define LOAD_CELL_ADC_READER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define LCAR_ASSERT_IMPLIES(label, cond, expect_expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (expect_expr)) else $error("lcar check failed");

`define LCAR_ASSERT_NEVER(label, bad_expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        !(bad_expr)) else $error("lcar check failed");

`else

`define LCAR_ASSERT_IMPLIES(label, cond, expect_expr)

`define LCAR_ASSERT_NEVER(label, bad_expr)

`endif

`endif

[rtl/lcar_pkg.sv]
package lcar_pkg;

    localparam int DATA_BITS  = 24;
    localparam int BIT_W      = 5;
    localparam int WAIT_W     = 20;
    localparam int SUM_W      = 32;
    localparam int FRAC_SHIFT = 12;
    localparam int WEIGHT_W   = 29;

    // shared divider: 36-bit dividend, 24-bit divisor, one quotient bit per cycle
    localparam int DIV_W = DATA_BITS + FRAC_SHIFT;
    localparam int DEN_W = 24;
    localparam int CNT_W = $clog2(DIV_W + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

    localparam logic [DEN_W-1:0]  SCALE_RESET   = 24'd107008;
    localparam logic [WAIT_W-1:0] TIMEOUT_RESET = 20'd200000;

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX   = 29'sh0FFFFFFF;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_FAULT = -29'sd15984;
    localparam logic [DIV_W-1:0] WEIGHT_MIN_Q = 36'd8;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_LAST
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_WSTART,
        SQ_WWAIT,
        SQ_TSTART,
        SQ_TWAIT,
        SQ_PUSH
    } seq_t;

endpackage

[rtl/lcar_div.sv]
// Restoring divider, one quotient bit per cycle. The dividend register
// shifts out dividend bits on top and takes quotient bits in at the bottom.
module lcar_div
    import lcar_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0] dvd_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_sub;
    logic           ge;

    assign rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DIV_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

[rtl/load_cell_adc_reader_unit.sv]
// Load cell converter reader. Each input request is one half bit period of
// the converter's serial clock: op = 0 is a timing tick carrying the sampled
// data line, op = 1 restarts the tare. Every request gives exactly one result
// request with the sck level to drive for the next tick, an end-of-reading
// flag, fault, the signed raw reading, the weight in 1/16 units and
// the tare busy flag.
// A tick that ends no reading goes from acceptance straight to the push state
// and on to the output register. A tick that ends a good reading above the
// offset first runs the shared 36-step restoring divider for the weight; the
// tick that closes a tare also runs it for the average. in_ready is low while
// a request is in work, so a new request is taken only after the last one has reached the output register.
// The result sits in an output register; a stalled receiver holds it there
// and the block finishes the next request up to that register meanwhile.
// Configuration (scale, timeout) is written on the cfg channel, always ready.
// Reset: serial state returns to waiting for data ready, the offset clears,
// and the good readings among the first TARE_READS are averaged into a
// new offset. The block is ready in the first cycle after reset.
`include "load_cell_adc_reader_unit_defines.svh"

module load_cell_adc_reader_unit
    import lcar_pkg::*;
#(
    parameter int unsigned TARE_READS = 10
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  logic                        dout,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        sck,
    output logic                        reading_done,
    output logic                        fault,
    output logic signed [DATA_BITS-1:0] raw_value,
    output logic signed [WEIGHT_W-1:0]  weight,
    output logic                        tare_busy,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int TARE_CNT_W = $clog2(TARE_READS + 1);

    // configuration
    logic [DEN_W-1:0]  scale_q8_reg;
    logic [WAIT_W-1:0] timeout_limit_reg;

    // serial and tare state
    phase_t                 phase_reg, phase_next;
    logic [BIT_W-1:0]       bit_index_reg, bit_index_next;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic [WAIT_W-1:0]      wait_ticks_reg, wait_ticks_next;
    logic [SUM_W-1:0]       tare_sum_reg, tare_sum_next;
    logic [TARE_CNT_W-1:0]  tare_att_reg, tare_att_next;
    logic [TARE_CNT_W-1:0]  tare_valid_reg, tare_valid_next;
    logic [DATA_BITS-1:0]   zero_offset_reg;
    logic                   tare_active_reg, tare_active_next;

    // sequencer
    seq_t seq_reg, seq_next;

    // result staging
    logic                       res_sck_reg;
    logic                       res_done_reg;
    logic                       res_fault_reg;
    logic [DATA_BITS-1:0]       res_raw_reg;
    logic signed [WEIGHT_W-1:0] res_weight_reg;
    logic                       res_busy_reg;
    logic                       need_t_reg;
    logic [DATA_BITS-1:0]       wdiff_reg;

    // output register
    logic                       out_valid_reg;
    logic                       sck_reg;
    logic                       done_reg;
    logic                       fault_reg;
    logic [DATA_BITS-1:0]       raw_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic                       busy_reg;

    // tick decode
    logic                 accept;
    logic                 tick_sck;
    logic                 end_att;
    logic                 end_flt;
    logic [DATA_BITS-1:0] end_raw;
    logic                 tare_fin;
    logic                 need_t;
    logic [DATA_BITS:0]   diff;
    logic                 diff_pos;

    // divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DEN_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [SUM_W-1:0] tare_mag;
    logic [SUM_W-1:0] tare_avg;
    logic signed [WEIGHT_W-1:0] weight_q;
    logic             out_free;

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // ---------------------------------------------------------------
    // One tick of the serial interface and tare bookkeeping
    // ---------------------------------------------------------------
    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        shift_next       = shift_reg;
        wait_ticks_next  = wait_ticks_reg;
        tare_sum_next    = tare_sum_reg;
        tare_att_next    = tare_att_reg;
        tare_valid_next  = tare_valid_reg;
        tare_active_next = tare_active_reg;
        tick_sck         = 1'b0;
        end_att          = 1'b0;
        end_flt          = 1'b0;
        end_raw          = '0;
        tare_fin         = 1'b0;
        need_t           = 1'b0;

        if (op)
        begin
            tare_sum_next    = '0;
            tare_att_next    = '0;
            tare_valid_next  = '0;
            tare_active_next = 1'b1;
            tick_sck         = (phase_reg == PH_HIGH) || (phase_reg == PH_LAST);
        end
        else
        begin
            unique case (phase_reg)
                PH_HIGH:
                begin
                    phase_next = PH_LOW;
                end
                PH_LOW:
                begin
                    shift_next     = {shift_reg[DATA_BITS-2:0], dout};
                    bit_index_next = bit_index_reg + 1'b1;
                    phase_next     = (bit_index_next >= BIT_W'(DATA_BITS)) ? PH_LAST : PH_HIGH;
                    tick_sck       = 1'b1;
                end
                PH_LAST:
                begin
                    phase_next     = PH_WAIT;
                    bit_index_next = '0;
                    end_att        = 1'b1;
                    end_raw        = shift_reg;
                    end_flt        = (shift_reg == '1);
                end
                PH_WAIT:
                begin
                    if (!dout)
                    begin
                        phase_next      = PH_HIGH;
                        bit_index_next  = '0;
                        shift_next      = '0;
                        wait_ticks_next = '0;
                        tick_sck        = 1'b1;
                    end
                    else if (wait_ticks_reg >= timeout_limit_reg)
                    begin
                        wait_ticks_next = '0;
                        end_att         = 1'b1;
                        end_flt         = 1'b1;
                        end_raw         = '1;
                    end
                    else
                    begin
                        wait_ticks_next = wait_ticks_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase

            if (end_att && tare_active_reg)
            begin
                if (!end_flt)
                begin
                    tare_sum_next   = tare_sum_reg
                                    + {{(SUM_W-DATA_BITS){end_raw[DATA_BITS-1]}}, end_raw};
                    tare_valid_next = tare_valid_reg + 1'b1;
                end
                tare_att_next = tare_att_reg + 1'b1;
                tare_fin      = (tare_att_next >= TARE_CNT_W'(TARE_READS));
                if (tare_fin)
                begin
                    tare_active_next = 1'b0;
                    need_t           = (tare_valid_next != '0);
                end
            end
        end
    end

    // difference against the offset held before this reading
    assign diff = {end_raw[DATA_BITS-1], end_raw}
                - {zero_offset_reg[DATA_BITS-1], zero_offset_reg};
    assign diff_pos = !diff[DATA_BITS] && (diff != '0);

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    if (end_att && !end_flt && diff_pos)
                        seq_next = SQ_WSTART;
                    else if (need_t)
                        seq_next = SQ_TSTART;
                    else
                        seq_next = SQ_PUSH;
                end
            end
            SQ_WSTART: seq_next = SQ_WWAIT;
            SQ_WWAIT:
            begin
                if (div_done)
                    seq_next = need_t_reg ? SQ_TSTART : SQ_PUSH;
            end
            SQ_TSTART: seq_next = SQ_TWAIT;
            SQ_TWAIT:
            begin
                if (div_done)
                    seq_next = SQ_PUSH;
            end
            SQ_PUSH:
            begin
                if (out_free)
                    seq_next = SQ_IDLE;
            end
            default: seq_next = SQ_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        tare_mag     = tare_sum_reg[SUM_W-1] ? (~tare_sum_reg + 1'b1) : tare_sum_reg;
        in_ready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = {wdiff_reg, {FRAC_SHIFT{1'b0}}};
        div_divisor  = scale_q8_reg;
        unique case (seq_reg)
            SQ_IDLE:
            begin
                in_ready = 1'b1;
            end
            SQ_WSTART:
            begin
                div_start = 1'b1;
            end
            SQ_TSTART:
            begin
                div_start    = 1'b1;
                div_dividend = {{(DIV_W-SUM_W){1'b0}}, tare_mag};
                div_divisor  = {{(DEN_W-TARE_CNT_W){1'b0}}, tare_valid_reg};
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    lcar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // quotient to Q.4 weight: saturate high, drop readings under one half
    always_comb
    begin
        if (div_quot[DIV_W-1:WEIGHT_W-1] != '0)
            weight_q = WEIGHT_MAX;
        else if (div_quot < WEIGHT_MIN_Q)
            weight_q = '0;
        else
            weight_q = div_quot[WEIGHT_W-1:0];
    end

    // average rounds toward zero: divide the magnitude, restore the sign
    assign tare_avg = tare_sum_reg[SUM_W-1] ? (~div_quot[SUM_W-1:0] + 1'b1)
                                            : div_quot[SUM_W-1:0];

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_q8_reg      <= SCALE_RESET;
            timeout_limit_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCALE:   scale_q8_reg      <= cfg_data[DEN_W-1:0];
                CFG_TIMEOUT: timeout_limit_reg <= cfg_data[WAIT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= SQ_IDLE;
            phase_reg       <= PH_WAIT;
            bit_index_reg   <= '0;
            shift_reg       <= '0;
            wait_ticks_reg  <= '0;
            tare_sum_reg    <= '0;
            tare_att_reg    <= '0;
            tare_valid_reg  <= '0;
            zero_offset_reg <= '0;
            tare_active_reg <= 1'b1;
            need_t_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            if (accept)
            begin
                phase_reg       <= phase_next;
                bit_index_reg   <= bit_index_next;
                shift_reg       <= shift_next;
                wait_ticks_reg  <= wait_ticks_next;
                tare_sum_reg    <= tare_sum_next;
                tare_att_reg    <= tare_att_next;
                tare_valid_reg  <= tare_valid_next;
                tare_active_reg <= tare_active_next;
                need_t_reg      <= need_t;
            end
            if (seq_reg == SQ_TWAIT && div_done)
                zero_offset_reg <= tare_avg[DATA_BITS-1:0];
            if (seq_reg == SQ_PUSH && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_sck_reg    <= tick_sck;
            res_done_reg   <= end_att;
            res_fault_reg  <= end_flt;
            res_raw_reg    <= end_raw;
            res_weight_reg <= end_flt ? WEIGHT_FAULT : '0;
            res_busy_reg   <= tare_active_next;
            wdiff_reg      <= diff[DATA_BITS-1:0];
        end
        else if (seq_reg == SQ_WWAIT && div_done)
        begin
            res_weight_reg <= weight_q;
        end

        if (seq_reg == SQ_PUSH && out_free)
        begin
            sck_reg    <= res_sck_reg;
            done_reg   <= res_done_reg;
            fault_reg  <= res_fault_reg;
            raw_reg    <= res_raw_reg;
            weight_reg <= res_weight_reg;
            busy_reg   <= res_busy_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sck          = sck_reg;
    assign reading_done = done_reg;
    assign fault        = fault_reg;
    assign raw_value    = raw_reg;
    assign weight       = weight_reg;
    assign tare_busy    = busy_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `LCAR_ASSERT_IMPLIES(a_last_after_all_bits, phase_reg == PH_LAST,
                         bit_index_reg == BIT_W'(DATA_BITS))
    `LCAR_ASSERT_NEVER(a_tare_valid_le_att, tare_valid_reg > tare_att_reg)
    `LCAR_ASSERT_IMPLIES(a_fault_weight, out_valid_reg && fault_reg,
                         done_reg && weight_reg == WEIGHT_FAULT)
    `LCAR_ASSERT_IMPLIES(a_quiet_fields, out_valid_reg && !done_reg,
                         !fault_reg && raw_reg == '0 && weight_reg == '0)

endmodule
